// ===== src/mu8d_pkg.sv =====
// Shared types and codes for the modified UTF-8 string decoder.
// No dependencies; every other file of the block imports this package.
package mu8d_pkg;

   typedef enum logic [2:0] {
      PH_LEN_HI = 3'b001,
      PH_LEN_LO = 3'b010,
      PH_BODY   = 3'b100
   } mu8d_phase_type;

   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_CHAR  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_PARTIAL  = 2'd1;
   localparam logic [1:0] ERR_BAD_CONT = 2'd2;
   localparam logic [1:0] ERR_BAD_LEAD = 2'd3;

   // Continuation codes: what the next body byte is expected to be.
   localparam logic [1:0] CONT_LEAD      = 2'd0;
   localparam logic [1:0] CONT_TWO_LAST  = 2'd1;
   localparam logic [1:0] CONT_THREE_MID = 2'd2;
   localparam logic [1:0] CONT_THREE_END = 2'd3;

   typedef struct packed {
      mu8d_phase_type phase;
      logic [7:0]     length_high;
      logic [15:0]    bytes_left;
      logic [15:0]    body_index;
      logic [15:0]    char_acc;
      logic [1:0]     cont_due;
      logic           discarding;
   } mu8d_state_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] char_code;
      logic [1:0]  error_code;
      logic [15:0] error_position;
      logic        frame_end;
   } mu8d_result_type;

endpackage

// ===== src/mu8d_step.sv =====
// Per-word decode logic: next decoder state and the result for one byte.
// Depends on mu8d_pkg for the state and result structs and the codes.
module mu8d_step (
   input  mu8d_pkg::mu8d_state_type  state_cur,
   input  logic [7:0]                in_byte,
   output mu8d_pkg::mu8d_state_type  state_next,
   output mu8d_pkg::mu8d_result_type result
);
   import mu8d_pkg::*;

   logic [3:0]  hi_nib;
   logic [21:0] acc_shift;
   logic [15:0] left_dec;
   logic [15:0] idx_p1;
   logic [15:0] idx_p2;
   logic [15:0] idx_p3;
   logic        is_cont;

   assign hi_nib    = in_byte[7:4];
   assign acc_shift = {state_cur.char_acc, in_byte[5:0]};
   assign left_dec  = state_cur.bytes_left - 16'd1;
   assign idx_p1    = state_cur.body_index + 16'd1;
   assign idx_p2    = state_cur.body_index + 16'd2;
   assign idx_p3    = state_cur.body_index + 16'd3;
   assign is_cont   = (in_byte[7:6] == 2'b10);

   always_comb begin
      state_next = state_cur;
      result     = '0;
      case (state_cur.phase)
         PH_LEN_LO: begin
            state_next.bytes_left = {state_cur.length_high, in_byte};
            state_next.body_index = '0;
            state_next.char_acc   = '0;
            state_next.cont_due   = CONT_LEAD;
            state_next.discarding = 1'b0;
            if ({state_cur.length_high, in_byte} == 16'd0) begin
               result.frame_end = 1'b1;
               state_next.phase = PH_LEN_HI;
            end else begin
               state_next.phase = PH_BODY;
            end
         end
         PH_BODY: begin
            if (state_cur.discarding) begin
               // The rest of a failed body is swallowed.
            end else if (state_cur.cont_due != CONT_LEAD) begin
               if (!is_cont) begin
                  result.kind       = KIND_ERROR;
                  result.error_code = ERR_BAD_CONT;
                  // Position is lead index + 2 for either character length.
                  result.error_position = (state_cur.cont_due == CONT_THREE_END) ?
                                          state_cur.body_index : idx_p1;
                  state_next.cont_due   = CONT_LEAD;
                  state_next.discarding = 1'b1;
               end else if (state_cur.cont_due == CONT_THREE_MID) begin
                  state_next.char_acc = acc_shift[15:0];
                  state_next.cont_due = CONT_THREE_END;
               end else begin
                  result.kind         = KIND_CHAR;
                  result.char_code    = acc_shift[15:0];
                  state_next.char_acc = '0;
                  state_next.cont_due = CONT_LEAD;
               end
            end else if (!in_byte[7]) begin
               result.kind      = KIND_CHAR;
               result.char_code = {8'd0, in_byte};
            end else if (hi_nib == 4'hC || hi_nib == 4'hD) begin
               if (state_cur.bytes_left < 16'd2) begin
                  result.kind           = KIND_ERROR;
                  result.error_code     = ERR_PARTIAL;
                  result.error_position = idx_p2;
                  state_next.discarding = 1'b1;
               end else begin
                  state_next.char_acc = {11'd0, in_byte[4:0]};
                  state_next.cont_due = CONT_TWO_LAST;
               end
            end else if (hi_nib == 4'hE) begin
               if (state_cur.bytes_left < 16'd3) begin
                  result.kind           = KIND_ERROR;
                  result.error_code     = ERR_PARTIAL;
                  result.error_position = idx_p3;
                  state_next.discarding = 1'b1;
               end else begin
                  state_next.char_acc = {12'd0, in_byte[3:0]};
                  state_next.cont_due = CONT_THREE_MID;
               end
            end else begin
               result.kind           = KIND_ERROR;
               result.error_code     = ERR_BAD_LEAD;
               result.error_position = state_cur.body_index;
               state_next.discarding = 1'b1;
            end
            state_next.body_index = idx_p1;
            state_next.bytes_left = left_dec;
            if (left_dec == 16'd0) begin
               result.frame_end      = 1'b1;
               state_next.phase      = PH_LEN_HI;
               state_next.body_index = '0;
               state_next.char_acc   = '0;
               state_next.cont_due   = CONT_LEAD;
               state_next.discarding = 1'b0;
            end
         end
         default: begin
            state_next.length_high = in_byte;
            state_next.phase       = PH_LEN_LO;
         end
      endcase
   end

endmodule

// ===== src/modified_utf8_string_decoder_core.sv =====
// Each accepted byte is held in the input register, then its result in the result register.
// Throughput: one byte per cycle while rsp_ready is high; every accepted word yields exactly one result word.
// The decoder state advances only when the input register hands its byte to the result register.
// Reset (synchronous, active high) empties both registers and returns the decoder to
// expecting the high length byte with all counters cleared.
// Depends on mu8d_pkg and mu8d_step.
module modified_utf8_string_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_char_code,
   output logic [1:0]  rsp_error_code,
   output logic [15:0] rsp_error_position,
   output logic        rsp_frame_end
);
   import mu8d_pkg::*;

   logic            in_valid_ff;
   logic            in_valid_in;
   logic [7:0]      in_byte_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   mu8d_result_type out_ff;
   mu8d_state_type  state_ff;
   mu8d_state_type  state_in;
   mu8d_result_type step_result;
   logic            advance;

   // The input register passes its word on whenever the result register is free.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   mu8d_step u_step (
      .state_cur  (state_ff),
      .in_byte    (in_byte_ff),
      .state_next (state_in),
      .result     (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{phase: PH_LEN_HI, default: '0};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_kind           = out_ff.kind;
   assign rsp_char_code      = out_ff.char_code;
   assign rsp_error_code     = out_ff.error_code;
   assign rsp_error_position = out_ff.error_position;
   assign rsp_frame_end      = out_ff.frame_end;

   a_error_has_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_ERROR) |-> (rsp_error_code != ERR_NONE))
      else $error("error result without an error code");

   a_discard_in_body: assert property (@(posedge clock) disable iff (reset)
      state_ff.discarding |-> (state_ff.phase == PH_BODY && state_ff.cont_due == CONT_LEAD))
      else $error("discarding outside a body or with a character pending");

   a_advance_fills_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("handed-off word did not reach the result register");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(out_ff) && rsp_valid))
      else $error("stalled result word was overwritten");

endmodule

// ===== tb/mu8d_decode_checker.sv =====
// Result checker for the modified UTF-8 string decoder: decodes every accepted input
// word in its own copy of the decoder and compares each accepted result word with it.
// Depends on mu8d_pkg for the phase, kind, error and continuation codes.
module mu8d_decode_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_kind,
   input  logic [15:0] rsp_char_code,
   input  logic [1:0]  rsp_error_code,
   input  logic [15:0] rsp_error_position,
   input  logic        rsp_frame_end,
   output int          mismatches,
   output int          words_due
);
   import mu8d_pkg::*;

   mu8d_state_type  decoder;
   mu8d_result_type decoded_q[$];

   function automatic void restart_body();
      decoder.body_index = '0;
      decoder.char_acc   = '0;
      decoder.cont_due   = CONT_LEAD;
      decoder.discarding = 1'b0;
   endfunction

   function automatic mu8d_result_type decode_byte(input logic [7:0] b);
      mu8d_result_type r;
      r = '0;
      case (decoder.phase)
         PH_LEN_LO: begin
            decoder.bytes_left = {decoder.length_high, b};
            restart_body();
            if (decoder.bytes_left == 16'd0) begin
               r.frame_end = 1'b1;
               decoder.phase = PH_LEN_HI;
            end else begin
               decoder.phase = PH_BODY;
            end
         end
         PH_BODY: begin
            if (decoder.discarding) begin
               // The rest of a failed body produces nothing.
            end else if (decoder.cont_due != CONT_LEAD) begin
               if (b[7:6] != 2'b10) begin
                  // Reported as lead index plus two, whichever byte failed.
                  r.kind = KIND_ERROR;
                  r.error_code = ERR_BAD_CONT;
                  r.error_position = (decoder.cont_due == CONT_THREE_END) ?
                                     decoder.body_index : decoder.body_index + 16'd1;
                  decoder.cont_due = CONT_LEAD;
                  decoder.discarding = 1'b1;
               end else if (decoder.cont_due == CONT_THREE_MID) begin
                  decoder.char_acc = {decoder.char_acc[9:0], b[5:0]};
                  decoder.cont_due = CONT_THREE_END;
               end else begin
                  r.kind = KIND_CHAR;
                  r.char_code = {decoder.char_acc[9:0], b[5:0]};
                  decoder.char_acc = '0;
                  decoder.cont_due = CONT_LEAD;
               end
            end else if (!b[7]) begin
               r.kind = KIND_CHAR;
               r.char_code = {8'h00, b};
            end else if (b[7:5] == 3'b110) begin
               if (decoder.bytes_left < 16'd2) begin
                  r.kind = KIND_ERROR;
                  r.error_code = ERR_PARTIAL;
                  r.error_position = decoder.body_index + 16'd2;
                  decoder.discarding = 1'b1;
               end else begin
                  decoder.char_acc = {11'd0, b[4:0]};
                  decoder.cont_due = CONT_TWO_LAST;
               end
            end else if (b[7:4] == 4'b1110) begin
               if (decoder.bytes_left < 16'd3) begin
                  r.kind = KIND_ERROR;
                  r.error_code = ERR_PARTIAL;
                  r.error_position = decoder.body_index + 16'd3;
                  decoder.discarding = 1'b1;
               end else begin
                  decoder.char_acc = {12'd0, b[3:0]};
                  decoder.cont_due = CONT_THREE_MID;
               end
            end else begin
               r.kind = KIND_ERROR;
               r.error_code = ERR_BAD_LEAD;
               r.error_position = decoder.body_index;
               decoder.discarding = 1'b1;
            end
            decoder.body_index = decoder.body_index + 16'd1;
            decoder.bytes_left = decoder.bytes_left - 16'd1;
            if (decoder.bytes_left == 16'd0) begin
               r.frame_end = 1'b1;
               decoder.phase = PH_LEN_HI;
               restart_body();
            end
         end
         default: begin
            decoder.length_high = b;
            decoder.phase = PH_LEN_LO;
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin : compare
      mu8d_result_type got;
      mu8d_result_type want;
      if (reset) begin
         decoder.phase = PH_LEN_HI;
         decoder.length_high = '0;
         decoder.bytes_left = '0;
         restart_body();
         decoded_q.delete();
      end else begin
         if (req_valid && req_ready)
            decoded_q.push_back(decode_byte(req_in_byte));
         if (rsp_valid && rsp_ready) begin
            got.kind = rsp_kind;
            got.char_code = rsp_char_code;
            got.error_code = rsp_error_code;
            got.error_position = rsp_error_position;
            got.frame_end = rsp_frame_end;
            if (decoded_q.size() == 0) begin
               if (mismatches < 10)
                  $display("checker: result word with none due: %s %0d %h %0d %0d %b",
                           "kind/char/err/pos/end", got.kind, got.char_code,
                           got.error_code, got.error_position, got.frame_end);
               mismatches++;
            end else begin
               want = decoded_q.pop_front();
               if (got !== want) begin
                  if (mismatches < 10) begin
                     $write("checker: expected kind %0d char %h err %0d pos %0d end %b, ",
                            want.kind, want.char_code, want.error_code,
                            want.error_position, want.frame_end);
                     $display("got kind %0d char %h err %0d pos %0d end %b",
                              got.kind, got.char_code, got.error_code,
                              got.error_position, got.frame_end);
                  end
                  mismatches++;
               end
            end
         end
      end
      words_due <= decoded_q.size();
   end

endmodule

// ===== tb/tb.sv =====
// Top of the decoder testbench: clock, reset, byte-stream stimulus and the verdict.
// Depends on mu8d_pkg, modified_utf8_string_decoder_core and mu8d_decode_checker.
module tb;

   localparam int CYCLE_LIMIT = 600000;
   localparam int HOLD_CYCLES = 60;
   localparam int PHASE_WORDS = 225;
   localparam int IDLE_PCT [4] = '{0, 61, 0, 24};
   localparam int STALL_PCT [4] = '{0, 0, 61, 24};

   // Empty frame; one of each character width at its extremes; bad continuation on
   // a middle byte; partial character on the last byte; bad lead then a swallowed byte.
   localparam logic [7:0] DIRECTED [25] = '{
      8'h00, 8'h00,
      8'h00, 8'h09, 8'h00, 8'h7F, 8'hC0, 8'h80, 8'hDF, 8'hBF, 8'hEF, 8'hBF, 8'hBF,
      8'h00, 8'h03, 8'hE1, 8'h41, 8'h42,
      8'h00, 8'h01, 8'hC5,
      8'h00, 8'h02, 8'hFF, 8'h80
   };

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_in_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_kind;
   logic [15:0] rsp_char_code;
   logic [1:0]  rsp_error_code;
   logic [15:0] rsp_error_position;
   logic        rsp_frame_end;

   int mismatches;
   int words_due;
   int idle_pct;
   int stall_pct;
   int hold_requests;
   int random_words;

   modified_utf8_string_decoder_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_in_byte        (req_in_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_char_code      (rsp_char_code),
      .rsp_error_code     (rsp_error_code),
      .rsp_error_position (rsp_error_position),
      .rsp_frame_end      (rsp_frame_end)
   );

   mu8d_decode_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_in_byte        (req_in_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_char_code      (rsp_char_code),
      .rsp_error_code     (rsp_error_code),
      .rsp_error_position (rsp_error_position),
      .rsp_frame_end      (rsp_frame_end),
      .mismatches         (mismatches),
      .words_due          (words_due)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb NOT OK");
      $finish;
   end

   // Called at a falling edge; returns at the falling edge after the word is taken.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin : receiver
      int served;
      int held;
      served = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (served != hold_requests) begin
            // Long hold-off so the decoder backs up and stops taking bytes.
            served++;
            rsp_ready <= 1'b0;
            for (held = 1; held < HOLD_CYCLES; held++) @(negedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   initial begin : stimulus
      logic [7:0]  body[$];
      logic [15:0] u;
      logic [15:0] frame_len;
      int          len;
      int          target;
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_byte = 8'h00;
      idle_pct = 0;
      stall_pct = 0;
      hold_requests = 0;
      random_words = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED[i]) send_byte(DIRECTED[i]);

      hold_requests++;
      for (int p = 0; p < 4; p++) begin
         idle_pct = IDLE_PCT[p];
         stall_pct = STALL_PCT[p];
         target = random_words + PHASE_WORDS;
         while (random_words < target) begin
            body.delete();
            len = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(10);
            if ($urandom_range(7) == 0) begin
               repeat (len) body.push_back(8'($urandom));
            end else begin
               while (body.size() < len) begin
                  u = 16'($urandom);
                  case ($urandom_range(2))
                     0: body.push_back({1'b0, u[6:0]});
                     1: begin
                        body.push_back({3'b110, u[10:6]});
                        body.push_back({2'b10, u[5:0]});
                     end
                     default: begin
                        body.push_back({4'b1110, u[15:12]});
                        body.push_back({2'b10, u[11:6]});
                        body.push_back({2'b10, u[5:0]});
                     end
                  endcase
               end
               // Cutting the last character short leaves a partial one at the end.
               while (body.size() > len) void'(body.pop_back());
               if (len > 0 && $urandom_range(4) == 0)
                  body[$urandom_range(len - 1)] = 8'($urandom);
            end
            frame_len = 16'(len);
            send_byte(frame_len[15:8]);
            send_byte(frame_len[7:0]);
            foreach (body[i]) send_byte(body[i]);
            random_words += len + 2;
         end
      end
      req_valid <= 1'b0;

      while (words_due != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (mismatches == 0 && words_due == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule
